// ===== hw/rtl/pcrds_pkg.sv =====
package pcrds_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_WRITE_POINT = 2'd0;
    localparam logic [1:0] CMD_WRITE_ROW   = 2'd1;
    localparam logic [1:0] CMD_ROTATE      = 2'd2;
    localparam logic [1:0] CMD_EMIT        = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_POINT_COUNT = 8'd0;
    localparam logic [7:0] CFG_SCALE       = 8'd1;

    localparam logic [6:0] POINT_COUNT_RESET = 7'd62;
    localparam logic [7:0] SCALE_RESET       = 8'd50;

    // screen center and depth offset, all in q14
    localparam logic signed [25:0] CENTER_X_Q14 = 26'sd2621440;
    localparam logic signed [25:0] CENTER_Y_Q14 = 26'sd1966080;
    localparam logic signed [17:0] DEPTH_OFS_Q14 = 18'sd49152;
    localparam logic [5:0] SHADE_GAIN = 6'd51;
    localparam logic [9:0] SHADE_MAX  = 10'd255;

    localparam logic signed [34:0] ROUND_HALF = 35'sd8192;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } point_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [5:0]  wr_idx;
        point_t      wr_point;
        point_t      key;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_EMIT
    } state_t;

endpackage

// ===== hw/rtl/pcrds_cell.sv =====
module pcrds_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                clk,
    input  pcrds_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       n,
    input  logic [CW-1:0]       s_lo,
    input  pcrds_pkg::point_t   right_point,
    input  logic                right_pass,
    output pcrds_pkg::point_t   point,
    output logic                pass
);

    localparam int IW = (CW > 6) ? CW : 6;

    pcrds_pkg::point_t point_reg;
    pcrds_pkg::point_t point_next;
    logic live;
    logic in_sorted;
    logic greater;

    // position flags against the broadcast key
    always_comb
    begin
        live      = CW'(IDX) < n;
        in_sorted = CW'(IDX) >= s_lo;
        greater   = live && in_sorted && (point_reg.z > ctrl.key.z);
        pass      = live && (!in_sorted || (point_reg.z <= ctrl.key.z));
    end

    // next content of this slot
    always_comb
    begin
        point_next = point_reg;
        case (ctrl.op)
            pcrds_pkg::CELL_WRITE:
            begin
                if (IW'(ctrl.wr_idx) == IW'(IDX))
                begin
                    point_next = ctrl.wr_point;
                end
            end
            pcrds_pkg::CELL_INSERT:
            begin
                if (live)
                begin
                    if (right_pass)
                    begin
                        point_next = right_point;
                    end
                    else if (!greater)
                    begin
                        point_next = ctrl.key;
                    end
                end
            end
            default:
            begin
                point_next = point_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

// ===== hw/rtl/pcrds_rot.sv =====
module pcrds_rot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pcrds_pkg::point_t head,
    input  pcrds_pkg::point_t mat [3],
    output logic              done,
    output pcrds_pkg::point_t result
);

    logic               issue_reg, issue_next;
    logic [1:0]         row_reg, row_next;
    logic [1:0]         col_reg, col_next;
    logic               pvalid_reg;
    logic [1:0]         prow_reg, pcol_reg;
    logic signed [31:0] prod_reg;
    logic signed [33:0] acc_reg;
    logic signed [33:0] sum;
    logic signed [34:0] rnd;
    logic signed [20:0] shifted;
    logic signed [15:0] sat;
    logic signed [15:0] mat_elem;
    logic signed [15:0] pt_elem;
    pcrds_pkg::point_t  mrow;
    pcrds_pkg::point_t  result_reg;
    logic               done_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mrow = mat[0];
        case (row_reg)
            2'd1:    mrow = mat[1];
            2'd2:    mrow = mat[2];
            default: mrow = mat[0];
        endcase
        case (col_reg)
            2'd1:
            begin
                mat_elem = mrow.y;
                pt_elem  = head.y;
            end
            2'd2:
            begin
                mat_elem = mrow.z;
                pt_elem  = head.z;
            end
            default:
            begin
                mat_elem = mrow.x;
                pt_elem  = head.x;
            end
        endcase
    end

    // row and column sequencing
    always_comb
    begin
        issue_next = issue_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (start)
        begin
            issue_next = 1'b1;
            row_next   = 2'd0;
            col_next   = 2'd0;
        end
        else if (issue_reg)
        begin
            if (col_reg == 2'd2)
            begin
                col_next = 2'd0;
                row_next = row_reg + 2'd1;
                if (row_reg == 2'd2)
                begin
                    issue_next = 1'b0;
                end
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    // accumulate, round half up and saturate
    always_comb
    begin
        sum     = ((pcol_reg == 2'd0) ? 34'sd0 : acc_reg) + 34'(prod_reg);
        rnd     = 35'(sum) + pcrds_pkg::ROUND_HALF;
        shifted = 21'(rnd >>> 14);
        if (shifted > 21'sd32767)
        begin
            sat = 16'sh7fff;
        end
        else if (shifted < -21'sd32768)
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = shifted[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            row_reg    <= 2'd0;
            col_reg    <= 2'd0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            issue_reg  <= issue_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            pvalid_reg <= issue_reg;
            done_reg   <= pvalid_reg && (prow_reg == 2'd2) && (pcol_reg == 2'd2);
        end
    end

    // product and accumulator data path
    always_ff @(posedge clk)
    begin
        prod_reg <= mat_elem * pt_elem;
        prow_reg <= row_reg;
        pcol_reg <= col_reg;
        if (pvalid_reg)
        begin
            acc_reg <= sum;
            if (pcol_reg == 2'd2)
            begin
                case (prow_reg)
                    2'd0:    result_reg.x <= sat;
                    2'd1:    result_reg.y <= sat;
                    default: result_reg.z <= sat;
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/pcrds_proj.sv =====
module pcrds_proj (
    input  pcrds_pkg::point_t  point,
    input  logic [7:0]         scale,
    output logic [10:0]        screen_x,
    output logic [10:0]        screen_y,
    output logic [7:0]         shade
);

    logic signed [24:0] px, py;
    logic signed [25:0] vx, vy;
    logic signed [25:0] tx, ty;
    logic signed [17:0] zs;
    logic signed [23:0] zp;
    logic [9:0]         sh;

    // center plus scaled coordinate, truncated toward zero
    always_comb
    begin
        px = $signed({1'b0, scale}) * point.x;
        py = $signed({1'b0, scale}) * point.y;
        vx = pcrds_pkg::CENTER_X_Q14 + 26'(px);
        vy = pcrds_pkg::CENTER_Y_Q14 + 26'(py);
        tx = (vx < 0) ? ((vx + 26'sd16383) >>> 14) : (vx >>> 14);
        ty = (vy < 0) ? ((vy + 26'sd16383) >>> 14) : (vy >>> 14);
        screen_x = tx[10:0];
        screen_y = ty[10:0];
    end

    // depth shade, the offset depth is always positive
    always_comb
    begin
        zs = 18'(point.z) + pcrds_pkg::DEPTH_OFS_Q14;
        zp = zs * $signed({1'b0, pcrds_pkg::SHADE_GAIN});
        sh = zp[23:14];
        shade = (sh > pcrds_pkg::SHADE_MAX) ? 8'hff : sh[7:0];
    end

endmodule

// ===== hw/rtl/point_cloud_rotate_depth_sort_top.sv =====
// Point store with rotate and depth sort. Points and rotation rows are written
// by commands on the input stream (tuser holds the command). A rotate request
// runs each point in use through one shared 16x16 multiplier, nine products
// per point, then inserts the result into a row of slot cells, so the sort is
// done when the last point is rotated. Rotate and emit then stream n results,
// one per cycle while the output is taken, the last one flagged by tlast. Point
// and row contents are undefined until written. No request is taken while a
// run is in progress.
module point_cloud_rotate_depth_sort_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index[5:0], value_0[21:6], value_1[37:22], value_2[53:38], zero fill
    input  logic [55:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // screen_x[10:0], screen_y[21:11], shade[29:22], zero fill
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    pcrds_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]         done_reg, done_next;
    logic                  start_reg, start_next;
    logic [6:0]            point_count_reg;
    logic [7:0]            scale_reg;
    pcrds_pkg::point_t     mat_reg [3];
    pcrds_pkg::cell_ctrl_t ctrl;
    logic [CW-1:0]         n;
    logic [CW-1:0]         s_lo;
    logic                  load;
    logic                  load_last;
    logic                  in_req;
    pcrds_pkg::point_t     in_point;
    pcrds_pkg::point_t     cell_point [MAX_POINTS];
    logic                  cell_pass  [MAX_POINTS];
    logic                  rot_done;
    pcrds_pkg::point_t     rot_res;
    logic [10:0]           proj_x, proj_y;
    logic [7:0]            proj_shade;
    logic                  ovalid_reg;
    logic                  olast_reg;
    logic [29:0]           odata_reg;

    assign in_req    = s_tvalid && s_tready;
    assign in_point  = '{z: s_tdata[53:38], y: s_tdata[37:22], x: s_tdata[21:6]};
    assign cfg_ready = 1'b1;

    // points in use, capped at capacity
    always_comb
    begin
        if (PW'(point_count_reg) > PW'(MAX_POINTS))
        begin
            n = CW'(MAX_POINTS);
        end
        else
        begin
            n = CW'(point_count_reg);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= pcrds_pkg::POINT_COUNT_RESET;
            scale_reg       <= pcrds_pkg::SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == pcrds_pkg::CFG_POINT_COUNT)
            begin
                point_count_reg <= cfg_data[6:0];
            end
            else if (cfg_index == pcrds_pkg::CFG_SCALE)
            begin
                scale_reg <= cfg_data;
            end
        end
    end

    // rotation rows
    always_ff @(posedge clk)
    begin
        if (in_req && (s_tuser == pcrds_pkg::CMD_WRITE_ROW) && (s_tdata[5:0] < 6'd3))
        begin
            mat_reg[s_tdata[1:0]] <= in_point;
        end
    end

    // sequencer: next state and cell control
    always_comb
    begin
        state_next    = state_reg;
        done_next     = done_reg;
        start_next    = 1'b0;
        s_tready      = 1'b0;
        load          = 1'b0;
        load_last     = 1'b0;
        ctrl.op       = pcrds_pkg::CELL_HOLD;
        ctrl.wr_idx   = s_tdata[5:0];
        ctrl.wr_point = in_point;
        ctrl.key      = cell_point[0];
        s_lo          = n;
        case (state_reg)
            pcrds_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (s_tuser)
                        pcrds_pkg::CMD_WRITE_POINT:
                        begin
                            ctrl.op = pcrds_pkg::CELL_WRITE;
                        end
                        pcrds_pkg::CMD_ROTATE:
                        begin
                            if (n != '0)
                            begin
                                state_next = pcrds_pkg::S_ROT;
                                start_next = 1'b1;
                                done_next  = '0;
                            end
                        end
                        pcrds_pkg::CMD_EMIT:
                        begin
                            if (n != '0)
                            begin
                                state_next = pcrds_pkg::S_EMIT;
                                done_next  = '0;
                            end
                        end
                        default:
                        begin
                            ctrl.op = pcrds_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end
            pcrds_pkg::S_ROT:
            begin
                ctrl.key = rot_res;
                s_lo     = n - done_reg;
                if (rot_done)
                begin
                    ctrl.op = pcrds_pkg::CELL_INSERT;
                    if (done_reg + CW'(1) == n)
                    begin
                        state_next = pcrds_pkg::S_EMIT;
                        done_next  = '0;
                    end
                    else
                    begin
                        done_next  = done_reg + CW'(1);
                        start_next = 1'b1;
                    end
                end
            end
            pcrds_pkg::S_EMIT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    load    = 1'b1;
                    ctrl.op = pcrds_pkg::CELL_INSERT;
                    if (done_reg + CW'(1) == n)
                    begin
                        load_last  = 1'b1;
                        state_next = pcrds_pkg::S_IDLE;
                        done_next  = '0;
                    end
                    else
                    begin
                        done_next = done_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = pcrds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcrds_pkg::S_IDLE;
            done_reg  <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            start_reg <= start_next;
        end
    end

    // row of slot cells
    for (genvar j = 0; j < MAX_POINTS; j++)
    begin : g_cell
        pcrds_pkg::point_t rp;
        logic              rpass;
        if (j == MAX_POINTS - 1)
        begin : g_end
            assign rp    = '0;
            assign rpass = 1'b0;
        end
        else
        begin : g_mid
            assign rp    = cell_point[j+1];
            assign rpass = cell_pass[j+1];
        end
        pcrds_cell #(
            .IDX (j),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .n           (n),
            .s_lo        (s_lo),
            .right_point (rp),
            .right_pass  (rpass),
            .point       (cell_point[j]),
            .pass        (cell_pass[j])
        );
    end

    pcrds_rot u_rot (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .head   (cell_point[0]),
        .mat    (mat_reg),
        .done   (rot_done),
        .result (rot_res)
    );

    pcrds_proj u_proj (
        .point    (cell_point[0]),
        .scale    (scale_reg),
        .screen_x (proj_x),
        .screen_y (proj_y),
        .shade    (proj_shade)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else if (load)
        begin
            ovalid_reg <= 1'b1;
            olast_reg  <= load_last;
        end
        else if (m_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            odata_reg <= {proj_shade, proj_y, proj_x};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, odata_reg};

    // rotator finishes only while a rotate run is active
    a_rot_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        rot_done |-> (state_reg == pcrds_pkg::S_ROT))
        else $error("rotator result outside a rotate run");

    // run counter stays below the point count
    a_done_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pcrds_pkg::S_IDLE) |-> (done_reg < n))
        else $error("run counter beyond point count");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_tready) |-> !load)
        else $error("output overwritten while stalled");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int NPTS = 64;
    localparam int SETTLE_CYCLES = 900;
    localparam logic [7:0] CFG_UNUSED = 8'd2;

    typedef struct {
        logic [1:0]         cmd;
        logic [5:0]         idx;
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
    } req_t;

    typedef struct {
        logic [10:0] sx;
        logic [10:0] sy;
        logic [7:0]  shade;
        logic        last;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // shadow copy of the block state
    logic signed [15:0] pts [NPTS][3];
    logic signed [15:0] rows [3][3];
    bit                 pt_written [NPTS];
    logic [6:0]         count_reg = pcrds_pkg::POINT_COUNT_RESET;
    logic [7:0]         scale_reg = pcrds_pkg::SCALE_RESET;

    pixel_t pixel_q[$];
    req_t   batch_q[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;

    point_cloud_rotate_depth_sort_top #(.MAX_POINTS(NPTS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int used_points();
        return (count_reg > NPTS) ? NPTS : int'(count_reg);
    endfunction

    function automatic logic signed [15:0] round_q14(input longint acc);
        longint r;
        r = (acc + 64'sd8192) >>> 14;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // rotate every point in use, then stable insertion sort by z
    task automatic rotate_sort_points();
        int n;
        int j;
        longint acc;
        logic signed [15:0] tmp [3];
        n = used_points();
        for (int i = 0; i < n; i++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc = 0;
                for (int c = 0; c < 3; c++)
                    acc += longint'(rows[r][c]) * longint'(pts[i][c]);
                tmp[r] = round_q14(acc);
            end
            for (int r = 0; r < 3; r++)
                pts[i][r] = tmp[r];
        end
        for (int i = 1; i < n; i++)
        begin
            for (int r = 0; r < 3; r++)
                tmp[r] = pts[i][r];
            j = i;
            while (j > 0 && pts[j-1][2] > tmp[2])
            begin
                for (int r = 0; r < 3; r++)
                    pts[j][r] = pts[j-1][r];
                j--;
            end
            for (int r = 0; r < 3; r++)
                pts[j][r] = tmp[r];
        end
    endtask

    // projection of every point in use into the expected pixel queue
    task automatic project_points();
        int n;
        longint s;
        longint sx;
        longint sy;
        longint sh;
        pixel_t px;
        n = used_points();
        s = longint'(scale_reg);
        for (int i = 0; i < n; i++)
        begin
            sx = (160 * 16384 + s * longint'(pts[i][0])) / 16384;
            sy = (120 * 16384 + s * longint'(pts[i][1])) / 16384;
            sh = (longint'(pts[i][2]) + 3 * 16384) * 51 / 16384;
            if (sh < 0) sh = 0;
            if (sh > 255) sh = 255;
            px.sx = sx[10:0];
            px.sy = sy[10:0];
            px.shade = sh[7:0];
            px.last = (i + 1 == n);
            pixel_q.push_back(px);
        end
    endtask

    task automatic apply_request(input req_t rq);
        case (rq.cmd)
            pcrds_pkg::CMD_WRITE_POINT:
            begin
                pts[rq.idx][0] = rq.v0;
                pts[rq.idx][1] = rq.v1;
                pts[rq.idx][2] = rq.v2;
                pt_written[rq.idx] = 1'b1;
            end
            pcrds_pkg::CMD_WRITE_ROW:
                if (rq.idx < 3)
                begin
                    rows[rq.idx][0] = rq.v0;
                    rows[rq.idx][1] = rq.v1;
                    rows[rq.idx][2] = rq.v2;
                end
            pcrds_pkg::CMD_ROTATE:
            begin
                rotate_sort_points();
                project_points();
            end
            default:
                project_points();
        endcase
    endtask

    // drive one request; valid stays high when another follows without a gap
    task automatic send_request(input req_t rq, input bit more);
        s_tvalid <= 1'b1;
        s_tuser <= rq.cmd;
        s_tdata <= {2'b00, rq.v2, rq.v1, rq.v0, rq.idx};
        do @(posedge clk); while (!s_tready);
        apply_request(rq);
        if (!more)
            s_tvalid <= 1'b0;
        else if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic run_batch();
        for (int i = 0; i < batch_q.size(); i++)
            send_request(batch_q[i], i != batch_q.size() - 1);
        batch_q.delete();
    endtask

    // wait for every pixel, then let a request with no output finish
    task automatic drain();
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == pcrds_pkg::CFG_POINT_COUNT)
            count_reg = val[6:0];
        else if (idx == pcrds_pkg::CFG_SCALE)
            scale_reg = val;
    endtask

    function automatic req_t make_req(input logic [1:0] c, input int i,
                                      input int a, input int b, input int d);
        req_t rq;
        rq.cmd = c;
        rq.idx = i[5:0];
        rq.v0 = a[15:0];
        rq.v1 = b[15:0];
        rq.v2 = d[15:0];
        return rq;
    endfunction

    function automatic req_t random_req();
        int r;
        int i;
        logic [1:0] c;
        r = $urandom_range(99);
        i = $urandom_range(63);
        if (r < 40)
            c = pcrds_pkg::CMD_WRITE_POINT;
        else if (r < 55)
        begin
            c = pcrds_pkg::CMD_WRITE_ROW;
            if ($urandom_range(3) != 0)
                i = $urandom_range(2);
        end
        else if (r < 80)
            c = pcrds_pkg::CMD_ROTATE;
        else
            c = pcrds_pkg::CMD_EMIT;
        return make_req(c, i, $urandom, $urandom, $urandom);
    endfunction

    // write every slot in use that has never been written
    task automatic fill_points();
        for (int i = 0; i < used_points(); i++)
            if (!pt_written[i])
                batch_q.push_back(make_req(pcrds_pkg::CMD_WRITE_POINT, i,
                                           $urandom, $urandom, $urandom));
    endtask

    // receiver stall
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // output checker
    always @(posedge clk)
    begin
        pixel_t px;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
                report($sformatf("unexpected pixel data=%h last=%b", m_tdata, m_tlast));
            else
            begin
                px = pixel_q.pop_front();
                if (m_tdata[10:0] !== px.sx)
                    report($sformatf("screen_x %h, want %h", m_tdata[10:0], px.sx));
                if (m_tdata[21:11] !== px.sy)
                    report($sformatf("screen_y %h, want %h", m_tdata[21:11], px.sy));
                if (m_tdata[29:22] !== px.shade)
                    report($sformatf("shade %h, want %h", m_tdata[29:22], px.shade));
                if (m_tlast !== px.last)
                    report($sformatf("last %b, want %b", m_tlast, px.last));
            end
        end
    end

    // directed table: identity, full scale points, saturating row, bad row index
    req_t directed [] = '{
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd0,  16'sd16384,  16'sd0,      16'sd0},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd1,  16'sd0,      16'sd16384,  16'sd0},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd2,  16'sd0,      16'sd0,      16'sd16384},
        '{pcrds_pkg::CMD_WRITE_POINT, 6'd0,  16'sd32767,  -16'sd32768, 16'sd32767},
        '{pcrds_pkg::CMD_WRITE_POINT, 6'd1,  -16'sd32768, 16'sd32767,  -16'sd32768},
        '{pcrds_pkg::CMD_EMIT,        6'd63, 16'sd0,      16'sd0,      16'sd0},
        '{pcrds_pkg::CMD_ROTATE,      6'd0,  16'sd0,      16'sd0,      16'sd0},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd3,  -16'sd1,     -16'sd1,     -16'sd1},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd63, 16'sd5,      16'sd5,      16'sd5},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd2,  -16'sd32768, -16'sd32768, -16'sd32768},
        '{pcrds_pkg::CMD_ROTATE,      6'd0,  16'sd0,      16'sd0,      16'sd0},
        '{pcrds_pkg::CMD_WRITE_POINT, 6'd63, -16'sd1,     16'sd1,      16'sd0},
        '{pcrds_pkg::CMD_WRITE_ROW,   6'd2,  16'sd0,      16'sd0,      16'sd16384},
        '{pcrds_pkg::CMD_EMIT,        6'd5,  -16'sd1,     -16'sd1,     -16'sd1}
    };

    int count_set [8] = '{1, 64, 127, 3, 6, 2, 8, 5};
    int pct_send [4] = '{0, 75, 0, 36};
    int pct_stall [4] = '{0, 0, 75, 36};

    initial
    begin
        int k;
        foreach (pt_written[i])
            pt_written[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with two points in use
        write_cfg(pcrds_pkg::CFG_POINT_COUNT, 8'd2);
        foreach (directed[i])
            batch_q.push_back(directed[i]);
        run_batch();
        drain();

        // zero count emits nothing; unknown register is ignored
        write_cfg(pcrds_pkg::CFG_POINT_COUNT, 8'd0);
        write_cfg(CFG_UNUSED, 8'hff);
        batch_q.push_back(make_req(pcrds_pkg::CMD_EMIT, 0, 0, 0, 0));
        batch_q.push_back(make_req(pcrds_pkg::CMD_ROTATE, 0, 0, 0, 0));
        run_batch();
        drain();

        // random phases over idling patterns
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = pct_send[p];
            stall_pct = pct_stall[p];
            for (int b = 0; b < 2; b++)
            begin
                k = p * 2 + b;
                write_cfg(pcrds_pkg::CFG_POINT_COUNT, 8'(count_set[k]));
                if (k == 0)
                    write_cfg(pcrds_pkg::CFG_SCALE, 8'd0);
                else if (k == 1)
                    write_cfg(pcrds_pkg::CFG_SCALE, 8'd255);
                else
                    write_cfg(pcrds_pkg::CFG_SCALE, 8'($urandom_range(255)));
                fill_points();
                for (int i = 0; i < 3; i++)
                    batch_q.push_back(random_req());
                batch_q.push_back(make_req(pcrds_pkg::CMD_EMIT, $urandom_range(63),
                                           $urandom, $urandom, $urandom));
                run_batch();
                drain();
            end
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pcrds_pkg.sv
hw/rtl/pcrds_cell.sv
hw/rtl/pcrds_rot.sv
hw/rtl/pcrds_proj.sv
hw/rtl/point_cloud_rotate_depth_sort_top.sv
test/tb.sv
